FILE: sv/mtam_pkg.sv
// mtam_pkg: shared types, constants and helpers for the threshold alarm monitor
// used by mtam_worst, mtam_core and multichannel_threshold_alarm_monitor
// no dependencies
package mtam_pkg;

  localparam int NUM_CHANNELS    = 8;
  localparam int CH_W            = 3;
  localparam int ALARM_PHASE_LEN = 6;
  localparam int PHASE_WRAP      = ALARM_PHASE_LEN * 2;
  localparam int SPEED_TIMEOUT   = 10;
  localparam int PERIOD_MIN      = 10;
  localparam int PERIOD_MAX      = 200;
  localparam int BLINK_TICKS     = 2;

  localparam logic [7:0] LAMP_BASE    = 8'hFE;
  localparam logic [7:0] LAMPS_OFF    = 8'hFF;
  localparam logic [7:0] PERIOD_RESET = 8'd20;

  localparam logic [3:0] KEY_DOWN10  = 4'd8;
  localparam logic [3:0] KEY_DOWN1   = 4'd9;
  localparam logic [3:0] KEY_UP1     = 4'd10;
  localparam logic [3:0] KEY_UP10    = 4'd11;
  localparam logic [3:0] KEY_SILENCE = 4'd15;

  localparam logic [7:0] LIMIT_RESET [8] = '{8'd10, 8'd20, 8'd25, 8'd100,
                                            8'd70, 8'd60, 8'd24, 8'd150};

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_KEY    = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_LABEL  = 2'd0,
    MODE_VALUE  = 2'd1,
    MODE_PERIOD = 2'd2,
    MODE_LIVE   = 2'd3
  } display_mode_t;

  typedef logic [NUM_CHANNELS-1:0][7:0] chan_bytes_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] sample_value;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      led_pattern;
    logic            beeper_level;
    logic [7:0]      alarm_flags;
    display_mode_t   display_mode;
    logic [7:0]      display_value;
    logic [CH_W-1:0] display_channel;
    logic [CH_W-1:0] next_scan_channel;
  } out_item_t;

  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] ch;
  } worst_t;

  // wraps to channel 0 after the last populated channel
  function automatic logic [CH_W-1:0] next_chan(logic [CH_W-1:0] c);
    logic [CH_W-1:0] n;
    n = (c >= CH_W'(NUM_CHANNELS - 1)) ? '0 : c + 1'b1;
    return n;
  endfunction

endpackage

FILE: sv/mtam_worst.sv
// mtam_worst: finds the channel with the largest excess over its limit
// depends on mtam_pkg
module mtam_worst (
  input  mtam_pkg::chan_bytes_t samples,
  input  mtam_pkg::chan_bytes_t limits,
  output mtam_pkg::worst_t      worst
);
  import mtam_pkg::*;

  logic [7:0] best;
  logic [7:0] ex;

  // first channel with the strictly largest excess wins
  always_comb begin
    best  = '0;
    ex    = '0;
    worst = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      ex = (samples[k] > limits[k]) ? samples[k] - limits[k] : 8'd0;
      if (ex > best) begin
        best        = ex;
        worst.found = 1'b1;
        worst.ch    = CH_W'(k);
      end
    end
  end

endmodule

FILE: sv/mtam_core.sv
// mtam_core: alarm state, key and tick handling, result formation
// depends on mtam_pkg and mtam_worst
module mtam_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  mtam_pkg::in_item_t   item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [7:0]           cfg_wdata,
  output mtam_pkg::out_item_t  result
);
  import mtam_pkg::*;

  chan_bytes_t     limits_r,  samples_r,  samples_nxt;
  logic [7:0]      alarm_r,   alarm_nxt;
  logic [CH_W-1:0] worst_r,   worst_nxt;
  logic            beep_en_r, beep_en_nxt;
  logic            beeper_r,  beeper_nxt;
  logic            blink_r,   blink_nxt;
  logic [7:0]      tick_r,    tick_nxt;
  logic [3:0]      phase_r,   phase_nxt;
  logic [CH_W-1:0] shown_r,   shown_nxt;
  logic [7:0]      period_r,  period_nxt;
  logic            speed_r,   speed_nxt;
  logic [CH_W-1:0] scan_r,    scan_nxt;
  logic [7:0]      lamp_r,    lamp_nxt;

  chan_bytes_t       search_in;
  worst_t            worst;
  logic signed [9:0] p;
  logic signed [9:0] delta;
  logic [15:0]       lamp_rot;
  logic [CH_W-1:0]   rd_sel;
  logic [7:0]        rd_val;
  display_mode_t     mode;

  // samples as they stand once the incoming reading is stored
  always_comb begin
    search_in         = samples_r;
    search_in[scan_r] = item.sample_value;
  end

  mtam_worst u_worst (
    .samples (search_in),
    .limits  (limits_r),
    .worst   (worst)
  );

  always_comb begin
    samples_nxt = samples_r;
    alarm_nxt   = alarm_r;
    worst_nxt   = worst_r;
    beep_en_nxt = beep_en_r;
    beeper_nxt  = beeper_r;
    blink_nxt   = blink_r;
    tick_nxt    = tick_r;
    phase_nxt   = phase_r;
    shown_nxt   = shown_r;
    period_nxt  = period_r;
    speed_nxt   = speed_r;
    scan_nxt    = scan_r;
    lamp_nxt    = lamp_r;
    delta       = '0;
    p           = '0;
    lamp_rot    = '0;

    if (advance) begin
      case (item.opcode)
        OP_SAMPLE: begin
          samples_nxt[scan_r] = item.sample_value;
          alarm_nxt[scan_r]   = item.sample_value > limits_r[scan_r];
          if (alarm_nxt != '0) begin
            if (worst.found) worst_nxt = worst.ch;
            if (worst_nxt != worst_r) phase_nxt = '0;
            if (alarm_r == '0) beep_en_nxt = 1'b1;
          end
          scan_nxt = next_chan(scan_r);
        end
        OP_KEY: begin
          if (alarm_r != '0) begin
            if (item.key_code == KEY_SILENCE) beep_en_nxt = 1'b0;
          end else if (!item.key_code[3]) begin
            if (int'(item.key_code) < NUM_CHANNELS) begin
              speed_nxt = 1'b0;
              shown_nxt = item.key_code[CH_W-1:0];
              tick_nxt  = '0;
            end
          end else if (item.key_code <= KEY_UP10) begin
            speed_nxt = 1'b1;
            tick_nxt  = '0;
            case (item.key_code)
              KEY_DOWN10: delta = -10'sd10;
              KEY_DOWN1:  delta = -10'sd1;
              KEY_UP1:    delta = 10'sd1;
              default:    delta = 10'sd10;
            endcase
            p = $signed({2'b00, period_r}) + delta;
            if (p < 10'(PERIOD_MIN)) p = 10'(PERIOD_MIN);
            if (p > 10'(PERIOD_MAX)) p = 10'(PERIOD_MAX);
            period_nxt = p[7:0];
          end
        end
        OP_TICK: begin
          tick_nxt = tick_r + 8'd1;
          if (alarm_r != '0) begin
            if (beep_en_r) beeper_nxt = ~beeper_r;
            if (tick_nxt > 8'(BLINK_TICKS)) begin
              blink_nxt = ~blink_r;
              tick_nxt  = '0;
              phase_nxt = phase_r + 4'd1;
              if (phase_nxt == 4'(PHASE_WRAP)) phase_nxt = '0;
            end
          end else if (speed_r) begin
            if (tick_nxt > 8'(SPEED_TIMEOUT)) begin
              speed_nxt = 1'b0;
              tick_nxt  = '0;
            end
          end else if (tick_nxt > period_r) begin
            tick_nxt  = '0;
            shown_nxt = next_chan(shown_r);
          end
          // lamps follow the state just updated
          lamp_rot = {LAMP_BASE, LAMP_BASE} << shown_nxt;
          if (alarm_r != '0) lamp_nxt = blink_nxt ? ~alarm_r : LAMPS_OFF;
          else if (speed_nxt) lamp_nxt = LAMPS_OFF;
          else lamp_nxt = lamp_rot[15:8];
        end
        default: ;
      endcase
    end
  end

  // result reflects the state after the event
  always_comb begin
    if (alarm_nxt != '0) begin
      mode   = (phase_nxt < 4'(ALARM_PHASE_LEN)) ? MODE_LABEL : MODE_VALUE;
      rd_sel = worst_nxt;
    end else begin
      mode   = speed_nxt ? MODE_PERIOD : MODE_LIVE;
      rd_sel = shown_nxt;
    end
    rd_val = samples_nxt[rd_sel];
    result.led_pattern       = lamp_nxt;
    result.beeper_level      = beeper_nxt;
    result.alarm_flags       = alarm_nxt;
    result.display_mode      = mode;
    result.display_channel   = rd_sel;
    result.next_scan_channel = scan_nxt;
    case (mode)
      MODE_LABEL:  result.display_value = '0;
      MODE_PERIOD: result.display_value = period_nxt;
      default:     result.display_value = rd_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        limits_r[k] <= LIMIT_RESET[k];
      end
      samples_r <= '0;
      alarm_r   <= '0;
      worst_r   <= '0;
      beep_en_r <= 1'b0;
      beeper_r  <= 1'b0;
      blink_r   <= 1'b0;
      tick_r    <= '0;
      phase_r   <= '0;
      shown_r   <= '0;
      period_r  <= PERIOD_RESET;
      speed_r   <= 1'b0;
      scan_r    <= '0;
      lamp_r    <= LAMPS_OFF;
    end else begin
      if (cfg_we && int'(cfg_idx) < NUM_CHANNELS) begin
        limits_r[cfg_idx[CH_W-1:0]] <= cfg_wdata;
      end
      samples_r <= samples_nxt;
      alarm_r   <= alarm_nxt;
      worst_r   <= worst_nxt;
      beep_en_r <= beep_en_nxt;
      beeper_r  <= beeper_nxt;
      blink_r   <= blink_nxt;
      tick_r    <= tick_nxt;
      phase_r   <= phase_nxt;
      shown_r   <= shown_nxt;
      period_r  <= period_nxt;
      speed_r   <= speed_nxt;
      scan_r    <= scan_nxt;
      lamp_r    <= lamp_nxt;
    end
  end

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    (period_r >= 8'(PERIOD_MIN)) && (period_r <= 8'(PERIOD_MAX)))
    else $error("rotation period out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < 4'(PHASE_WRAP))
    else $error("phase counter past wrap point");

  a_beep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (alarm_r == '0) |=> $stable(beeper_r))
    else $error("beeper toggled without alarm");

endmodule

FILE: sv/multichannel_threshold_alarm_monitor.sv
// multichannel_threshold_alarm_monitor: top level with input and result registers
// depends on mtam_pkg and mtam_core
//
// Eight-channel gas alarm controller. Each transfer on the in_ channel is one
// event: an ADC sample for the channel named by the last next_scan_channel, a
// key-down code, or a timer tick. Every event yields exactly one result transfer
// that shows the state after the event. Thresholds are written through cfg_
// (index 0..7 selects the channel limit, other indexes are dropped) while the
// block is idle; the user is bound to this, the block itself does not enforce it.
// An accepted event sits in an input register, is processed by combinational
// logic (including an eight-way excess compare) and lands in a result register,
// which raises out_valid; throughput is one event per cycle as long as out_ready
// is high. A stalled result holds the pipe but the input register still accepts
// while it is empty.
module multichannel_threshold_alarm_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtam_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mtam_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [7:0]          cfg_wdata
);
  import mtam_pkg::*;

  in_item_t  in_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t result;
  logic      advance;

  // event moves from input register into result register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mtam_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (in_r),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r  <= in_data;
    if (advance)              out_r <= result;
  end

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("pending event did not reach result register");

  a_mode_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.alarm_flags == '0) ==
      (out_r.display_mode == MODE_PERIOD || out_r.display_mode == MODE_LIVE)))
    else $error("display mode disagrees with alarm flags");

  a_label_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.display_mode == MODE_LABEL) |-> (out_r.display_value == '0))
    else $error("label mode shows a value");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_r))
    else $error("result overwritten while stalled");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking regression for the eight-channel threshold alarm monitor
// depends on mtam_pkg and multichannel_threshold_alarm_monitor; holds its own event predictor

// predictor of the monitor state plus the queue of reports still to come
class alarm_scoreboard;
  logic [7:0] limit_q [mtam_pkg::NUM_CHANNELS];
  logic [7:0] samples [mtam_pkg::NUM_CHANNELS];
  logic [7:0] alarm_bits;
  logic [2:0] worst_ch;
  logic       beep_en;
  logic       beeper;
  logic       blink;
  logic [7:0] tick_cnt;
  logic [3:0] phase_cnt;
  logic [2:0] shown_ch;
  logic [7:0] period;
  logic       adjust_mode;
  logic [2:0] scan_ch;
  logic [7:0] lamps;

  mtam_pkg::out_item_t expected_reports[$];
  int failures;
  int checked;
  int alarm_reports;
  int period_reports;
  int rotations;

  function new();
    for (int k = 0; k < mtam_pkg::NUM_CHANNELS; k++) begin
      limit_q[k] = mtam_pkg::LIMIT_RESET[k];
      samples[k] = '0;
    end
    alarm_bits = '0;
    worst_ch   = '0;
    beep_en    = 1'b0;
    beeper     = 1'b0;
    blink      = 1'b0;
    tick_cnt   = '0;
    phase_cnt  = '0;
    shown_ch   = '0;
    period     = mtam_pkg::PERIOD_RESET;
    adjust_mode = 1'b0;
    scan_ch    = '0;
    lamps      = mtam_pkg::LAMPS_OFF;
    failures   = 0;
    checked    = 0;
    alarm_reports  = 0;
    period_reports = 0;
    rotations      = 0;
  endfunction

  function void set_limit(int ch, logic [7:0] value);
    limit_q[ch] = value;
  endfunction

  function int pending_count();
    return expected_reports.size();
  endfunction

  function logic [2:0] following_channel(logic [2:0] ch);
    return (ch == 3'(mtam_pkg::NUM_CHANNELS - 1)) ? 3'd0 : ch + 3'd1;
  endfunction

  // largest excess over all channels, first one wins, none keeps the old pick
  function void find_worst();
    logic [7:0] best;
    logic [7:0] excess;
    logic [2:0] prev;
    best = '0;
    prev = worst_ch;
    for (int k = 0; k < mtam_pkg::NUM_CHANNELS; k++) begin
      excess = (samples[k] > limit_q[k]) ? samples[k] - limit_q[k] : 8'd0;
      if (excess > best) begin
        best = excess;
        worst_ch = 3'(k);
      end
    end
    if (worst_ch != prev) phase_cnt = '0;
  endfunction

  function void take_sample(logic [7:0] value);
    logic [2:0] ch;
    logic       was_quiet;
    ch = scan_ch;
    was_quiet = (alarm_bits == 0);
    samples[ch] = value;
    alarm_bits[ch] = (value > limit_q[ch]);
    if (alarm_bits != 0) begin
      find_worst();
      if (was_quiet) beep_en = 1'b1;
    end
    scan_ch = following_channel(ch);
  endfunction

  function void take_key(logic [3:0] key);
    int p;
    if (alarm_bits != 0) begin
      if (key == mtam_pkg::KEY_SILENCE) beep_en = 1'b0;
      return;
    end
    if (key < mtam_pkg::NUM_CHANNELS) begin
      adjust_mode = 1'b0;
      shown_ch = key[2:0];
      tick_cnt = '0;
    end else if (key <= mtam_pkg::KEY_UP10) begin
      adjust_mode = 1'b1;
      tick_cnt = '0;
      p = int'(period);
      case (key)
        mtam_pkg::KEY_DOWN10: p = p - 10;
        mtam_pkg::KEY_DOWN1:  p = p - 1;
        mtam_pkg::KEY_UP1:    p = p + 1;
        default:              p = p + 10;
      endcase
      if (p < mtam_pkg::PERIOD_MIN) p = mtam_pkg::PERIOD_MIN;
      if (p > mtam_pkg::PERIOD_MAX) p = mtam_pkg::PERIOD_MAX;
      period = 8'(p);
    end
  endfunction

  function void take_tick();
    logic [15:0] rot;
    tick_cnt = tick_cnt + 8'd1;
    if (alarm_bits != 0) begin
      if (beep_en) beeper = ~beeper;
      if (tick_cnt > mtam_pkg::BLINK_TICKS) begin
        blink = ~blink;
        tick_cnt = '0;
        phase_cnt = phase_cnt + 4'd1;
        if (phase_cnt == mtam_pkg::PHASE_WRAP) phase_cnt = '0;
      end
    end else if (adjust_mode) begin
      if (tick_cnt > mtam_pkg::SPEED_TIMEOUT) begin
        adjust_mode = 1'b0;
        tick_cnt = '0;
      end
    end else if (tick_cnt > period) begin
      tick_cnt = '0;
      shown_ch = following_channel(shown_ch);
      rotations++;
    end

    if (alarm_bits != 0) begin
      lamps = blink ? ~alarm_bits : mtam_pkg::LAMPS_OFF;
    end else if (adjust_mode) begin
      lamps = mtam_pkg::LAMPS_OFF;
    end else begin
      rot = {mtam_pkg::LAMP_BASE, mtam_pkg::LAMP_BASE} << shown_ch;
      lamps = rot[15:8];
    end
  endfunction

  // an accepted event: advance the state and queue the report it must produce
  function void note_event(mtam_pkg::in_item_t ev);
    mtam_pkg::out_item_t r;
    case (ev.opcode)
      mtam_pkg::OP_SAMPLE: take_sample(ev.sample_value);
      mtam_pkg::OP_KEY:    take_key(ev.key_code);
      mtam_pkg::OP_TICK:   take_tick();
      default: ;
    endcase
    r.led_pattern  = lamps;
    r.beeper_level = beeper;
    r.alarm_flags  = alarm_bits;
    if (alarm_bits != 0) begin
      r.display_mode = (phase_cnt < mtam_pkg::ALARM_PHASE_LEN) ? mtam_pkg::MODE_LABEL
                                                               : mtam_pkg::MODE_VALUE;
      r.display_value = (r.display_mode == mtam_pkg::MODE_LABEL) ? 8'd0 : samples[worst_ch];
      r.display_channel = worst_ch;
      alarm_reports++;
    end else if (adjust_mode) begin
      r.display_mode    = mtam_pkg::MODE_PERIOD;
      r.display_value   = period;
      r.display_channel = shown_ch;
      period_reports++;
    end else begin
      r.display_mode    = mtam_pkg::MODE_LIVE;
      r.display_value   = samples[shown_ch];
      r.display_channel = shown_ch;
    end
    r.next_scan_channel = scan_ch;
    expected_reports.push_back(r);
  endfunction

  function void check_report(mtam_pkg::out_item_t got);
    mtam_pkg::out_item_t exp;
    logic bad;
    if (expected_reports.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("error: report with nothing expected: %h", got);
      return;
    end
    exp = expected_reports.pop_front();
    checked++;
    bad = (got.led_pattern       !== exp.led_pattern)
       || (got.beeper_level      !== exp.beeper_level)
       || (got.alarm_flags       !== exp.alarm_flags)
       || (got.display_mode      !== exp.display_mode)
       || (got.display_value     !== exp.display_value)
       || (got.display_channel   !== exp.display_channel)
       || (got.next_scan_channel !== exp.next_scan_channel);
    if (bad) begin
      failures++;
      if (failures <= 10) begin
        $display("error: report %0d exp lamps=%h beep=%b flags=%h mode=%0d val=%0d ch=%0d scan=%0d",
                 checked, exp.led_pattern, exp.beeper_level, exp.alarm_flags,
                 exp.display_mode, exp.display_value, exp.display_channel,
                 exp.next_scan_channel);
        $display("       got lamps=%h beep=%b flags=%h mode=%0d val=%0d ch=%0d scan=%0d",
                 got.led_pattern, got.beeper_level, got.alarm_flags,
                 got.display_mode, got.display_value, got.display_channel,
                 got.next_scan_channel);
      end
    end
  endfunction
endclass

module testbench;
  import mtam_pkg::*;

  localparam int         RESET_CYCLES   = 12;
  localparam int         NUM_PHASES     = 8;
  localparam int         PHASE_EVENTS   = 110;
  localparam int         LONG_HOLD      = 400;
  localparam int         DRAIN_CYCLES   = 6;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [2:0] REG_LIMIT_CH0  = 3'd0;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic [2:0] cfg_idx  = '0;
  logic [7:0] cfg_wdata = '0;

  alarm_scoreboard sb = new();

  // stimulus-side knobs and bookkeeping
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         events_sent    = 0;
  int         limit_writes   = 0;
  int         quiet_cycles   = 0;
  logic       hold_req       = 1'b0;
  logic       hold_taken     = 1'b0;
  int         hold_left      = 0;
  logic [2:0] gen_scan       = '0;
  logic [7:0] stim_limits [NUM_CHANNELS];

  multichannel_threshold_alarm_monitor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // transfer monitor: inputs feed the predictor before the same edge's result is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_event(in_data);
      if (out_valid && out_ready) sb.check_report(out_data);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout: no transfer for %0d cycles, %0d reports outstanding",
             WATCHDOG_LIMIT, sb.pending_count());
    $display("multichannel_threshold_alarm_monitor regression: fail");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off counted here so the pipe backs up
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left = LONG_HOLD;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // fill the fields the opcode ignores with junk so every bit toggles
  function automatic in_item_t make_event(opcode_t op, logic [7:0] value, logic [3:0] key);
    in_item_t ev;
    ev.opcode       = op;
    ev.sample_value = (op == OP_SAMPLE) ? value : 8'($urandom);
    ev.key_code     = (op == OP_KEY) ? key : 4'($urandom);
    return ev;
  endfunction

  // one event on the input channel, with a random idle gap in front of it
  task automatic offer_event(in_item_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    events_sent++;
    if (ev.opcode == OP_SAMPLE)
      gen_scan = (gen_scan == 3'(NUM_CHANNELS - 1)) ? 3'd0 : gen_scan + 3'd1;
  endtask

  // stop offering and wait until every report is back
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all eight thresholds, one register per cycle, only while the block is idle
  task automatic write_limits(logic [7:0] lim [NUM_CHANNELS]);
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_LIMIT_CH0 + 3'(k);
      cfg_wdata <= lim[k];
      @(posedge clk);
      sb.set_limit(k, lim[k]);
      stim_limits[k] = lim[k];
      limit_writes++;
    end
    cfg_we <= 1'b0;
  endtask

  // values placed around the threshold of the channel about to be sampled
  function automatic logic [7:0] pick_sample(bit quiet);
    logic [7:0] lim;
    lim = stim_limits[gen_scan];
    if (quiet) return 8'($urandom_range(int'(lim), 0));
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return lim;
      3:       return (lim == 8'd255) ? lim : lim + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  // a burst of related events: tick runs, samples, quiet sweeps, key runs, noise
  task automatic random_burst();
    int sel;
    int n;
    logic [3:0] key;
    sel = $urandom_range(99);
    if (sel < 25) begin
      n = $urandom_range(40, 1);
      repeat (n) offer_event(make_event(OP_TICK, '0, '0));
    end else if (sel < 45) begin
      n = $urandom_range(8, 1);
      repeat (n) offer_event(make_event(OP_SAMPLE, pick_sample(1'b0), '0));
    end else if (sel < 58) begin
      // every channel back at or under its limit so the keys come alive again
      repeat (NUM_CHANNELS) offer_event(make_event(OP_SAMPLE, pick_sample(1'b1), '0));
    end else if (sel < 80) begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        if ($urandom_range(1)) key = KEY_DOWN10 + 4'($urandom_range(3));
        else key = 4'($urandom);
        offer_event(make_event(OP_KEY, '0, key));
      end
    end else if (sel < 93) begin
      // long tick run so rotation, the speed timeout and the alarm phases are reached
      n = $urandom_range(220, 30);
      repeat (n) offer_event(make_event(OP_TICK, '0, '0));
    end else begin
      n = $urandom_range(3, 1);
      repeat (n) begin
        if ($urandom_range(1)) offer_event(make_event(OP_NONE, '0, '0));
        else offer_event(in_item_t'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] lim [NUM_CHANNELS];
    int target;
    for (int k = 0; k < NUM_CHANNELS; k++) stim_limits[k] = LIMIT_RESET[k];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset thresholds, no idling
    offer_event(make_event(OP_TICK, '0, '0));
    offer_event(make_event(OP_NONE, '0, '0));      // unused opcode only reports
    offer_event(make_event(OP_KEY, '0, KEY_DOWN10)); // period 20 down to the minimum of 10
    offer_event(make_event(OP_KEY, '0, KEY_DOWN1));
    offer_event(make_event(OP_KEY, '0, KEY_UP1));
    offer_event(make_event(OP_KEY, '0, KEY_UP10));
    offer_event(make_event(OP_KEY, '0, 4'd12));     // upper keys ignored when quiet
    offer_event(make_event(OP_KEY, '0, KEY_SILENCE));
    offer_event(make_event(OP_KEY, '0, 4'd2));      // pick shown channel
    offer_event(make_event(OP_TICK, '0, '0));
    offer_event(make_event(OP_SAMPLE, 8'd0, '0));   // channel 0 quiet
    offer_event(make_event(OP_SAMPLE, 8'd255, '0)); // channel 1 starts an alarm
    offer_event(make_event(OP_KEY, '0, 4'd4));      // ignored during alarm
    repeat (3) offer_event(make_event(OP_TICK, '0, '0));
    offer_event(make_event(OP_KEY, '0, KEY_SILENCE));
    offer_event(make_event(OP_TICK, '0, '0));       // beeper level held after silence
    repeat (NUM_CHANNELS) offer_event(make_event(OP_SAMPLE, 8'd0, '0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_block();
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        case (ph)
          1:       lim[k] = 8'd0;
          2, 7:    lim[k] = 8'd255;
          3:       lim[k] = LIMIT_RESET[k];
          4:       lim[k] = (k % 2 == 0) ? 8'd0 : 8'd255;
          5:       lim[k] = 8'($urandom_range(40));
          default: lim[k] = 8'($urandom);
        endcase
      end
      write_limits(lim);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 0) hold_req <= 1'b1;
      target = events_sent + PHASE_EVENTS;
      while (events_sent < target) random_burst();
    end
    drain_block();

    $display("covered %0d events over %0d threshold settings (%0d register writes), %0d reports checked",
             events_sent, NUM_PHASES, limit_writes, sb.checked);
    $display("reports in alarm %0d, in period adjust %0d, display rotations %0d",
             sb.alarm_reports, sb.period_reports, sb.rotations);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("multichannel_threshold_alarm_monitor regression: pass");
    end else begin
      $display("%0d failures", sb.failures);
      $display("multichannel_threshold_alarm_monitor regression: fail");
    end
    $finish;
  end
endmodule
